// ===== hw/rtl/dpbc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpbc_pkg
// Shared types, constants and fixed-point helpers for the depth back-projector.
// ----------------------------------------------------------------------------
package dpbc_pkg;

  localparam int unsigned ImgWidthDef  = 640;
  localparam int unsigned ImgHeightDef = 480;

  localparam logic [4:0] SlotInvfx  = 5'd0;
  localparam logic [4:0] SlotInvfy  = 5'd1;
  localparam logic [4:0] SlotCx     = 5'd2;
  localparam logic [4:0] SlotCy     = 5'd3;
  localparam logic [4:0] SlotCam    = 5'd4;
  localparam logic [4:0] SlotWorld  = 5'd16;
  localparam logic [4:0] SlotOrigin = 5'd28;
  localparam logic [4:0] SlotSide   = 5'd31;

  localparam logic FuncLoad  = 1'b0;
  localparam logic FuncPixel = 1'b1;

  typedef struct packed {
    logic               func;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic [11:0]        pixel_row;
    logic [11:0]        pixel_col;
    logic [23:0]        depth;
  } req_in_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } req_out_t;

  // classified pixel handed from front to back
  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
    logic [23:0] depth;
  } pix_t;

  typedef logic signed [31:0] word_t;

  function automatic word_t sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       sat32 = 32'sh7fffffff;
    else if (v < -66'sd2147483648) sat32 = 32'sh80000000;
    else                           sat32 = v[31:0];
  endfunction

endpackage

// ===== hw/rtl/depth_pixel_backproject_crop.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backproject_crop
// Depth pixel back-projection with rigid transforms and cube crop.
// ----------------------------------------------------------------------------
// Path: a kept pixel's result passes through the queue, seven stages and the
// output skid before it is presented; a load takes effect at once.
// Throughput: one request per cycle while the output drains; a load waits until
// queue and datapath are empty; the datapath holds when the skid is full.
// Reset: asynchronous, clears the coefficient table, queue and pipeline.
module depth_pixel_backproject_crop #(
  parameter int unsigned IMG_WIDTH  = dpbc_pkg::ImgWidthDef,
  parameter int unsigned IMG_HEIGHT = dpbc_pkg::ImgHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dpbc_pkg::req_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dpbc_pkg::req_out_t out_data_o
);

  dpbc_pkg::word_t coef_q [32];
  logic            wr_en;
  logic [4:0]      wr_idx;
  dpbc_pkg::word_t wr_val;
  logic            qv, qs, busy;
  dpbc_pkg::pix_t  qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 32; i++) coef_q[i] <= '0;
    end else if (wr_en) begin
      coef_q[wr_idx] <= wr_val;
    end
  end

  dpbc_front #(.ImgWidth(IMG_WIDTH), .ImgHeight(IMG_HEIGHT)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i, .busy_i(busy),
    .wr_en_o(wr_en), .wr_idx_o(wr_idx), .wr_val_o(wr_val),
    .q_valid_o(qv), .q_stall_i(qs), .q_data_o(qd)
  );

  dpbc_back u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_stall_o(qs), .q_data_i(qd),
    .coef_i(coef_q), .busy_o(busy), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ===== hw/rtl/dpbc_front.sv =====
// ----------------------------------------------------------------------------
// dpbc_front
// Accepts requests, writes coefficient loads, drops out-of-image pixels and
// queues the rest for the datapath.
// ----------------------------------------------------------------------------
module dpbc_front #(
  parameter int unsigned ImgWidth  = dpbc_pkg::ImgWidthDef,
  parameter int unsigned ImgHeight = dpbc_pkg::ImgHeightDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dpbc_pkg::req_in_t in_data_i,
  input  logic              busy_i,
  output logic              wr_en_o,
  output logic [4:0]        wr_idx_o,
  output dpbc_pkg::word_t   wr_val_o,
  output logic              q_valid_o,
  input  logic              q_stall_i,
  output dpbc_pkg::pix_t    q_data_o
);

  logic [1:0]     cnt_q, cnt_d;
  logic           rd_q, rd_d, wr_q, wr_d;
  dpbc_pkg::pix_t mem_q [2];
  logic           acc, push, pop, in_img;

  assign in_img   = ({1'b0, in_data_i.pixel_row} < 13'(ImgHeight)) &&
                    ({1'b0, in_data_i.pixel_col} < 13'(ImgWidth));
  // a load waits until no pixel is queued or in the datapath
  assign in_stall_o = (cnt_q == 2'd2) ||
                      ((in_data_i.func == dpbc_pkg::FuncLoad) && ((cnt_q != 2'd0) || busy_i));
  assign acc      = in_valid_i && !in_stall_o;
  assign push     = acc && (in_data_i.func == dpbc_pkg::FuncPixel) && in_img;
  assign pop      = q_valid_o && !q_stall_i;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_q];

  assign wr_en_o  = acc && (in_data_i.func == dpbc_pkg::FuncLoad);
  assign wr_idx_o = in_data_i.coef_index;
  assign wr_val_o = in_data_i.coef_value;

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    wr_d  = wr_q ^ push;
    rd_d  = rd_q ^ pop;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      rd_q  <= rd_d;
      wr_q  <= wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= '{in_data_i.pixel_row, in_data_i.pixel_col, in_data_i.depth};
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !pop) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("bad count");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (cnt_q == 2'd0) && !busy_i) else $error("load while busy");
`endif

endmodule

// ===== hw/rtl/dpbc_back.sv =====
// ----------------------------------------------------------------------------
// dpbc_back
// Seven-stage datapath: projection, camera-to-base transform, cube test,
// base-to-world transform, with a two-entry output skid.
// ----------------------------------------------------------------------------
module dpbc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_stall_o,
  input  dpbc_pkg::pix_t       q_data_i,
  input  dpbc_pkg::word_t      coef_i [32],
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output dpbc_pkg::req_out_t   out_data_o
);

  localparam int unsigned Stages = 7;

  logic [Stages-1:0] v_q;
  logic              adv;
  logic signed [33:0]  dx_q, dy_q;
  logic signed [31:0]  z1_q, z2_q, z3_q;
  dpbc_pkg::word_t     tx_q, ty_q, cx_q, cy_q;
  logic signed [63:0]  pc_q [3][3];
  dpbc_pkg::word_t     b_q [3];
  logic                in_d, in_q, keep_q;
  logic signed [63:0]  pw_q [3][3];
  dpbc_pkg::word_t     w_q [3];

  logic [1:0]          fcnt_q;
  logic                frd_q, fwr_q;
  dpbc_pkg::req_out_t  fmem_q [2];
  logic                push, pop;

  // whole pipe holds only when a kept point finds the skid full with no pop
  assign adv       = !(v_q[Stages-1] && keep_q) || (fcnt_q != 2'd2) || pop;
  assign q_stall_o = !adv;
  assign busy_o    = |v_q;

  assign push = v_q[Stages-1] && keep_q && adv;
  assign pop  = out_valid_o && !out_stall_i;
  assign out_valid_o = fcnt_q != 2'd0;
  assign out_data_o  = fmem_q[frd_q];

  always_comb begin
    in_d = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (33'(b_q[i]) < 33'(coef_i[28+i]) ||
          33'(b_q[i]) > 33'(coef_i[28+i]) + 33'(coef_i[dpbc_pkg::SlotSide]))
        in_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= '0;
      fcnt_q <= '0;
      frd_q  <= 1'b0;
      fwr_q  <= 1'b0;
    end else begin
      if (adv) v_q <= {v_q[Stages-2:0], q_valid_i};
      fcnt_q <= fcnt_q + 2'(push) - 2'(pop);
      frd_q  <= frd_q ^ pop;
      fwr_q  <= fwr_q ^ push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // s0: centre offsets
      dx_q <= $signed({2'b00, q_data_i.pixel_col, 20'd0}) - 34'(coef_i[dpbc_pkg::SlotCx]);
      dy_q <= $signed({2'b00, q_data_i.pixel_row, 20'd0}) - 34'(coef_i[dpbc_pkg::SlotCy]);
      z1_q <= $signed({8'd0, q_data_i.depth});
      // s1: times depth
      tx_q <= dpbc_pkg::sat32(66'((dx_q * $signed({1'b0, z1_q})) >>> 20));
      ty_q <= dpbc_pkg::sat32(66'((dy_q * $signed({1'b0, z1_q})) >>> 20));
      z2_q <= z1_q;
      // s2: times inverse focal length
      cx_q <= dpbc_pkg::sat32(66'((64'(tx_q) * 64'(coef_i[dpbc_pkg::SlotInvfx])) >>> 30));
      cy_q <= dpbc_pkg::sat32(66'((64'(ty_q) * 64'(coef_i[dpbc_pkg::SlotInvfy])) >>> 30));
      z3_q <= z2_q;
      // s3: camera-to-base products
      for (int i = 0; i < 3; i++) begin
        pc_q[i][0] <= (64'(coef_i[4*i+4]) * 64'(cx_q)) >>> 20;
        pc_q[i][1] <= (64'(coef_i[4*i+5]) * 64'(cy_q)) >>> 20;
        pc_q[i][2] <= (64'(coef_i[4*i+6]) * 64'(z3_q)) >>> 20;
      end
      // s4: sum
      for (int i = 0; i < 3; i++)
        b_q[i] <= dpbc_pkg::sat32(66'(pc_q[i][0]) + 66'(pc_q[i][1]) + 66'(pc_q[i][2])
                                  + 66'(coef_i[4*i+7]));
      // s5: cube test and world products
      in_q <= in_d;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++)
          pw_q[i][j] <= (64'(coef_i[16+4*i+j]) * 64'(b_q[j])) >>> 20;
      end
      // s6: sum
      keep_q <= in_q;
      for (int i = 0; i < 3; i++)
        w_q[i] <= dpbc_pkg::sat32(66'(pw_q[i][0]) + 66'(pw_q[i][1]) + 66'(pw_q[i][2])
                                  + 66'(coef_i[16+4*i+3]));
    end
    if (push) fmem_q[fwr_q] <= '{w_q[0], w_q[1], w_q[2]};
  end

`ifndef SYNTHESIS
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q == 2'd2 && !pop |-> !push) else $error("skid overflow");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q != 2'd3) else $error("bad skid count");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |-> v_q[Stages-1] && keep_q) else $error("stall state");
`endif

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for depth_pixel_backproject_crop: coefficient loads and depth
// pixels are driven through the request handshake, kept points are predicted
// in fixed point and checked in order against the block's results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class point_board;
  logic signed [31:0] coefs[32];
  dpbc_pkg::req_out_t pending[$];
  int errors;

  function new();
    foreach (coefs[i]) coefs[i] = '0;
    errors = 0;
  endfunction

  function automatic longint fl(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint proj(longint pix, int cslot, int islot, longint z);
    longint d, t;
    d = (pix <<< 20) - longint'(coefs[cslot]);
    t = sat(fl(d * z, 20));
    return sat(fl(t * longint'(coefs[islot]), 30));
  endfunction

  function automatic void xform(int b, longint p[3], output longint q[3]);
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(coefs[b + i * 4 + 3]);
      for (int j = 0; j < 3; j++)
        acc += fl(longint'(coefs[b + i * 4 + j]) * p[j], 20);
      q[i] = sat(acc);
    end
  endfunction

  function void note_request(dpbc_pkg::req_in_t r);
    longint cam[3], bp[3], wp[3];
    longint lo;
    bit keep;
    dpbc_pkg::req_out_t o;
    if (r.func == dpbc_pkg::FuncLoad) begin
      coefs[r.coef_index] = r.coef_value;
      return;
    end
    if (r.pixel_row >= dpbc_pkg::ImgHeightDef || r.pixel_col >= dpbc_pkg::ImgWidthDef)
      return;
    cam[0] = proj(longint'(r.pixel_col), dpbc_pkg::SlotCx, dpbc_pkg::SlotInvfx,
                  longint'(r.depth));
    cam[1] = proj(longint'(r.pixel_row), dpbc_pkg::SlotCy, dpbc_pkg::SlotInvfy,
                  longint'(r.depth));
    cam[2] = longint'(r.depth);
    xform(dpbc_pkg::SlotCam, cam, bp);
    keep = 1;
    for (int i = 0; i < 3; i++) begin
      lo = longint'(coefs[dpbc_pkg::SlotOrigin + i]);
      if (bp[i] < lo || bp[i] > lo + longint'(coefs[dpbc_pkg::SlotSide])) keep = 0;
    end
    if (!keep) return;
    xform(dpbc_pkg::SlotWorld, bp, wp);
    o.world_x = wp[0][31:0];
    o.world_y = wp[1][31:0];
    o.world_z = wp[2][31:0];
    pending = {pending, o};
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_point(dpbc_pkg::req_out_t g);
    dpbc_pkg::req_out_t e;
    if (pending.size() == 0) begin
      report($sformatf("unexpected point %h", g));
      return;
    end
    e = pending.pop_front();
    if (g.world_x !== e.world_x) report($sformatf("x %h exp %h", g.world_x, e.world_x));
    if (g.world_y !== e.world_y) report($sformatf("y %h exp %h", g.world_y, e.world_y));
    if (g.world_z !== e.world_z) report($sformatf("z %h exp %h", g.world_z, e.world_z));
  endtask
endclass

module tb;

  logic               clk_i, rst_ni;
  logic               in_valid, in_stall, out_valid, out_stall;
  dpbc_pkg::req_in_t  in_data;
  dpbc_pkg::req_out_t out_data;

  point_board board;
  bit       quiet_phase, hold_rx;
  int       idle_cycles;

  depth_pixel_backproject_crop dut (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (in_valid && !in_stall) board.note_request(in_data);
    if (out_valid && !out_stall) board.check_point(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver
  initial begin
    out_stall = 1;
    forever begin
      @(negedge clk_i);
      out_stall <= hold_rx || (!quiet_phase && $urandom_range(99) < 6);
    end
  end

  task send(dpbc_pkg::req_in_t r);
    in_data  <= r;
    in_valid <= 1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    if (!quiet_phase && $urandom_range(99) < 6) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  task load(logic [4:0] s, logic [31:0] v);
    dpbc_pkg::req_in_t r;
    r = '0;
    r.func = dpbc_pkg::FuncLoad;
    r.coef_index = s;
    r.coef_value = v;
    r.pixel_row = 12'($urandom);
    r.pixel_col = 12'($urandom);
    r.depth = 24'($urandom);
    send(r);
  endtask

  task pixel(logic [11:0] row, logic [11:0] col, logic [23:0] z);
    dpbc_pkg::req_in_t r;
    r.func = dpbc_pkg::FuncPixel;
    r.coef_index = 5'($urandom);
    r.coef_value = $urandom;
    r.pixel_row = row;
    r.pixel_col = col;
    r.depth = z;
    send(r);
  endtask

  // identity-like pose with a cube around the view
  task sane_pose();
    for (int i = 0; i < 12; i++) begin
      load(5'(dpbc_pkg::SlotCam + i),
           (i % 5 == 0) ? 32'h0010_0000 : 32'($urandom_range(0, 4096) - 2048));
      load(5'(dpbc_pkg::SlotWorld + i),
           (i % 5 == 0) ? 32'h0010_0000 : 32'($urandom_range(0, 1 << 21)));
    end
    load(dpbc_pkg::SlotInvfx, 32'd2_000_000 + $urandom_range(0, 400000));
    load(dpbc_pkg::SlotInvfy, 32'd2_000_000 + $urandom_range(0, 400000));
    load(dpbc_pkg::SlotCx, 32'd320 << 20);
    load(dpbc_pkg::SlotCy, 32'd240 << 20);
    load(dpbc_pkg::SlotOrigin, -(32'd8 << 20));
    load(5'(dpbc_pkg::SlotOrigin + 1), -(32'd8 << 20));
    load(5'(dpbc_pkg::SlotOrigin + 2), 32'd0);
    load(dpbc_pkg::SlotSide, 32'd12 << 20);
  endtask

  task rand_pixel();
    int k;
    k = $urandom_range(99);
    if (k < 85)
      pixel(12'($urandom_range(0, 479)), 12'($urandom_range(0, 639)),
            24'($urandom_range(0, 1 << 23)));
    else if (k < 95)
      pixel(12'($urandom), 12'($urandom), 24'($urandom));
    else
      pixel(12'($urandom_range(0, 479)), 12'($urandom_range(0, 639)), 24'hFFFFFF);
  endtask

  initial begin
    board = new();
    rst_ni = 0;
    in_valid = 0;
    in_data = '0;
    hold_rx = 0;
    quiet_phase = 0;
    idle_cycles = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: cleared table, extremes, outside-image, negative side
    pixel(0, 0, 0);
    pixel(479, 639, 24'hFFFFFF);
    pixel(480, 0, 5);
    pixel(0, 640, 5);
    pixel(12'hFFF, 12'hFFF, 24'hFFFFFF);
    sane_pose();
    pixel(240, 320, 24'h100000);
    pixel(0, 0, 24'hFFFFFF);
    pixel(479, 639, 0);
    load(dpbc_pkg::SlotSide, 32'h8000_0000);
    pixel(240, 320, 24'h100000);
    load(dpbc_pkg::SlotSide, 32'h7FFF_FFFF);
    load(dpbc_pkg::SlotOrigin, 32'h8000_0000);
    load(5'(dpbc_pkg::SlotOrigin + 1), 32'h8000_0000);
    load(5'(dpbc_pkg::SlotOrigin + 2), 32'h8000_0000);
    load(dpbc_pkg::SlotInvfx, 32'h7FFF_FFFF);
    load(dpbc_pkg::SlotCam, 32'h7FFF_FFFF);
    load(dpbc_pkg::SlotWorld, 32'h8000_0000);
    pixel(479, 639, 24'hFFFFFF);
    pixel(0, 0, 24'hFFFFFF);

    // random: mostly pixels against sane poses, some random loads
    for (int n = 0; n < 240; n++) begin
      if (n == 100) quiet_phase = 1;
      if (n == 160) quiet_phase = 0;
      if (n == 200) begin
        hold_rx = 1;
        fork
          begin
            repeat (60) @(negedge clk_i);
            hold_rx = 0;
          end
        join_none
      end
      if (n % 80 == 0 && n != 200) sane_pose();
      if ($urandom_range(99) < 8) load(5'($urandom), $urandom);
      else rand_pixel();
    end
    in_valid <= 0;

    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/dpbc_pkg.sv
hw/rtl/dpbc_front.sv
hw/rtl/dpbc_back.sv
hw/rtl/depth_pixel_backproject_crop.sv
sim/tb.sv
